// ===== rtl/bimode_pkg.sv =====
// bimode_pkg: shared types, codes and counter helpers for the bi-mode predictor
// no dependencies; imported by the interfaces, bimode_idx and bimode_branch_predictor

package bimode_pkg;

    localparam int CMD_W    = 3;
    localparam int PC_W     = 32;
    localparam int HIST_W   = 16;
    localparam int HLEN_W   = 5;
    localparam int HIDX_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOOKUP      = 3'd0,
        CMD_UPDATE      = 3'd1,
        CMD_HIST_SHIFT  = 3'd2,
        CMD_RECOVER     = 3'd3,
        CMD_FLUSH       = 3'd4
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_XOR_MODE           = 2'd0,
        CFG_HISTORY_BITS       = 2'd1,
        CFG_HISTORY_INDEX_BITS = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LK1,
        S_LK2,
        S_UPD,
        S_SPEC,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              xor_mode;
        logic [HLEN_W-1:0] history_bits;
        logic [HIDX_W-1:0] history_index_bits;
    } t_cfg;

    // reset contents of the counter banks
    localparam logic [3:0] BANKS_INIT = 4'b1001;  // taken bank 2, not-taken bank 1

    function automatic logic [HLEN_W-1:0] hist_len(input logic [HLEN_W-1:0] hb);
        return (hb > HLEN_W'(HIST_W)) ? HLEN_W'(HIST_W) : hb;
    endfunction

    function automatic logic [HIST_W-1:0] hist_mask(input logic [HLEN_W-1:0] hb);
        logic [HIST_W:0] full;
        full = ((HIST_W+1)'(1) << hist_len(hb)) - (HIST_W+1)'(1);
        return full[HIST_W-1:0];
    endfunction

    // saturating 2-bit counter step
    function automatic logic [1:0] ctr_train(input logic [1:0] c, input logic taken);
        logic [1:0] r;
        r = c;
        if (taken) begin
            if (c != 2'd3) r = c + 2'd1;
        end else begin
            if (c != 2'd0) r = c - 2'd1;
        end
        return r;
    endfunction

endpackage

// ===== rtl/bimode_req_if.sv =====
// bimode_req_if: request channel of the bi-mode predictor, valid/ready handshake
// depends on bimode_pkg for field widths

interface bimode_req_if import bimode_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [PC_W-1:0]   pc;
    logic [HIST_W-1:0] history_snapshot;
    logic              bank;
    logic              direction_bit;

    modport source (
        output valid, cmd, pc, history_snapshot, bank, direction_bit,
        input  ready
    );
    modport sink (
        input  valid, cmd, pc, history_snapshot, bank, direction_bit,
        output ready
    );
endinterface

// ===== rtl/bimode_rsp_if.sv =====
// bimode_rsp_if: result channel of the bi-mode predictor, valid/ready handshake
// depends on bimode_pkg for field widths

interface bimode_rsp_if import bimode_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              predict_taken;
    logic [HIST_W-1:0] history_out;
    logic              bank_out;

    modport source (
        output valid, predict_taken, history_out, bank_out,
        input  ready
    );
    modport sink (
        input  valid, predict_taken, history_out, bank_out,
        output ready
    );
endinterface

// ===== rtl/bimode_ram.sv =====
// bimode_ram: generic single write port, single read port ram with registered read
// no dependencies

module bimode_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/bimode_idx.sv =====
// bimode_idx: counter-bank index from branch address and history
// depends on bimode_pkg (t_cfg, hist_len)

module bimode_idx import bimode_pkg::*; #(
    parameter int COUNTER_ENTRIES = 4096
) (
    input  t_cfg              i_cfg,
    input  logic [PC_W-1:0]   i_pc,
    input  logic [HIST_W-1:0] i_hist,
    output logic [(COUNTER_ENTRIES > 1 ? $clog2(COUNTER_ENTRIES) : 1)-1:0] o_idx
);
    localparam int IW = (COUNTER_ENTRIES > 1) ? $clog2(COUNTER_ENTRIES) : 1;
    localparam logic [HLEN_W-1:0] LG = HLEN_W'($clog2(COUNTER_ENTRIES + 1) - 1);
    localparam logic [IW-1:0] IDX_MASK = IW'(COUNTER_ENTRIES - 1);

    logic [HLEN_W-1:0] w_len;
    logic [HLEN_W-1:0] w_sh;
    logic [IW-1:0]     w_raw;

    always_comb begin
        w_len = hist_len(i_cfg.history_bits);
        w_sh  = (LG > w_len) ? (LG - w_len) : '0;
        if (i_cfg.xor_mode) begin
            w_raw = IW'(i_pc) ^ (IW'(i_hist) << w_sh);
        end else begin
            w_raw = (IW'(i_pc) << w_len) | IW'(i_hist);
        end
        o_idx = w_raw & IDX_MASK;
    end
endmodule

// ===== rtl/bimode_branch_predictor.sv =====
// bimode_branch_predictor: top level, history table, counter banks and chooser
// in block rams with a read-modify-write sequencer
// depends on bimode_pkg, bimode_req_if, bimode_rsp_if, bimode_ram, bimode_idx
// a lookup passes S_LK1 (history, chooser read), S_LK2 (counter-pair read), S_DONE;
//   update and history shift pass S_UPD or S_SPEC; recover, flush and unknown commands
//   go straight to S_DONE, which holds while the output stalls; one request at a time
//   (ready only in S_IDLE); lookup order set by chained history, counter-bank ram reads
// reset clears control state, then a clearing pass over max(HISTORY_ENTRIES,
//   COUNTER_ENTRIES) addresses (4096 by default) fills the rams; no requests meanwhile

module bimode_branch_predictor import bimode_pkg::*; #(
    parameter int HISTORY_ENTRIES = 1024,
    parameter int COUNTER_ENTRIES = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bimode_req_if.sink            i_req,
    bimode_rsp_if.source          o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int HA_W  = (HISTORY_ENTRIES > 1) ? $clog2(HISTORY_ENTRIES) : 1;
    localparam int CA_W  = (COUNTER_ENTRIES > 1) ? $clog2(COUNTER_ENTRIES) : 1;
    localparam int CLR_N = (HISTORY_ENTRIES > COUNTER_ENTRIES) ? HISTORY_ENTRIES
                                                                : COUNTER_ENTRIES;
    localparam int CLR_W = $clog2(CLR_N);
    localparam logic [HLEN_W-1:0] HLOG = HLEN_W'($clog2(HISTORY_ENTRIES + 1) - 1);
    localparam logic [HA_W-1:0] HA_MASK = HA_W'(HISTORY_ENTRIES - 1);
    localparam logic [CA_W-1:0] CA_MASK = CA_W'(COUNTER_ENTRIES - 1);

    // configuration
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.xor_mode           <= 1'b1;
            r_cfg.history_bits       <= HLEN_W'(8);
            r_cfg.history_index_bits <= HIDX_W'(10);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_XOR_MODE:           r_cfg.xor_mode <= i_cfg_data[0];
                CFG_HISTORY_BITS:       r_cfg.history_bits <= i_cfg_data[HLEN_W-1:0];
                CFG_HISTORY_INDEX_BITS: r_cfg.history_index_bits <= i_cfg_data[HIDX_W-1:0];
                default: ;
            endcase
        end
    end

    // state
    t_state            r_state, n_state;
    logic [CLR_W-1:0]  r_clr, n_clr;
    logic [PC_W-1:0]   r_pc, n_pc;
    logic [HA_W-1:0]   r_hi, n_hi;
    logic [CA_W-1:0]   r_ci, n_ci;
    logic [CA_W-1:0]   r_li, n_li;
    logic              r_bank, n_bank;
    logic              r_dir, n_dir;
    logic              r_p_pred, n_p_pred;
    logic [HIST_W-1:0] r_p_hist, n_p_hist;
    logic              r_p_bank, n_p_bank;
    logic              r_out_valid, n_out_valid;
    logic              r_out_pred, n_out_pred;
    logic [HIST_W-1:0] r_out_hist, n_out_hist;
    logic              r_out_bank, n_out_bank;

    // ram ports
    logic              w_h_we, w_h_re;
    logic [HA_W-1:0]   w_h_waddr, w_h_raddr;
    logic [HIST_W-1:0] w_h_wdata, w_h_rdata;
    logic              w_c_we, w_c_re;
    logic [CA_W-1:0]   w_c_waddr, w_c_raddr;
    logic [1:0]        w_c_wdata, w_c_rdata;
    logic              w_b_we, w_b_re;
    logic [CA_W-1:0]   w_b_waddr, w_b_raddr;
    logic [3:0]        w_b_wdata, w_b_rdata;

    // index helpers
    logic [HLEN_W-1:0] w_ib;
    logic [HA_W:0]     w_ib_mask;
    logic [HA_W-1:0]   w_hi_in;
    logic [CA_W-1:0]   w_ci_in;
    logic [PC_W-1:0]   w_idx_pc;
    logic [HIST_W-1:0] w_idx_hist;
    logic [CA_W-1:0]   w_li;
    logic              w_accept;
    logic [1:0]        w_ctr, w_ctr_new;
    logic              w_pred, w_sel;
    logic [HIST_W-1:0] w_hmask;

    assign w_ib      = ({1'b0, r_cfg.history_index_bits} > HLOG)
                     ? HLOG : {1'b0, r_cfg.history_index_bits};
    assign w_ib_mask = ((HA_W+1)'(1) << w_ib) - (HA_W+1)'(1);
    assign w_hi_in   = i_req.pc[HA_W-1:0] & w_ib_mask[HA_W-1:0] & HA_MASK;
    assign w_ci_in   = i_req.pc[CA_W-1:0] & CA_MASK;
    assign w_hmask   = hist_mask(r_cfg.history_bits);

    // lookup's second step indexes with the stored history, update with the snapshot
    assign w_idx_pc   = (r_state == S_LK1) ? r_pc : i_req.pc;
    assign w_idx_hist = (r_state == S_LK1) ? w_h_rdata : i_req.history_snapshot;

    bimode_idx #(.COUNTER_ENTRIES(COUNTER_ENTRIES)) u_idx (
        .i_cfg  (r_cfg),
        .i_pc   (w_idx_pc),
        .i_hist (w_idx_hist),
        .o_idx  (w_li)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && (r_state == S_IDLE);

    assign w_ctr     = r_bank ? w_b_rdata[3:2] : w_b_rdata[1:0];
    assign w_ctr_new = ctr_train(w_ctr, r_dir);
    assign w_pred    = w_ctr[1];
    assign w_sel     = w_c_rdata[1];

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_pc        = r_pc;
        n_hi        = r_hi;
        n_ci        = r_ci;
        n_li        = r_li;
        n_bank      = r_bank;
        n_dir       = r_dir;
        n_p_pred    = r_p_pred;
        n_p_hist    = r_p_hist;
        n_p_bank    = r_p_bank;
        n_out_valid = r_out_valid;
        n_out_pred  = r_out_pred;
        n_out_hist  = r_out_hist;
        n_out_bank  = r_out_bank;

        w_h_we    = 1'b0;
        w_h_waddr = r_hi;
        w_h_wdata = '0;
        w_h_re    = 1'b0;
        w_h_raddr = w_hi_in;
        w_c_we    = 1'b0;
        w_c_waddr = r_ci;
        w_c_wdata = w_c_rdata;
        w_c_re    = 1'b0;
        w_c_raddr = w_ci_in;
        w_b_we    = 1'b0;
        w_b_waddr = r_li;
        w_b_wdata = w_b_rdata;
        w_b_re    = 1'b0;
        w_b_raddr = w_li;

        if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                if ({1'b0, r_clr} < (CLR_W+1)'(HISTORY_ENTRIES)) begin
                    w_h_we    = 1'b1;
                    w_h_waddr = r_clr[HA_W-1:0];
                    w_h_wdata = '0;
                end
                if ({1'b0, r_clr} < (CLR_W+1)'(COUNTER_ENTRIES)) begin
                    w_c_we    = 1'b1;
                    w_c_waddr = r_clr[CA_W-1:0];
                    w_c_wdata = {r_clr[0], ~r_clr[0]};
                    w_b_we    = 1'b1;
                    w_b_waddr = r_clr[CA_W-1:0];
                    w_b_wdata = BANKS_INIT;
                end
                n_clr = r_clr + CLR_W'(1);
                if (r_clr == CLR_W'(CLR_N - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_pc     = i_req.pc;
                    n_hi     = w_hi_in;
                    n_ci     = w_ci_in;
                    n_li     = w_li;
                    n_bank   = i_req.bank;
                    n_dir    = i_req.direction_bit;
                    n_p_pred = 1'b0;
                    n_p_hist = '0;
                    n_p_bank = 1'b0;
                    w_h_re   = 1'b1;
                    w_c_re   = 1'b1;
                    w_b_re   = 1'b1;
                    n_state  = S_DONE;
                    unique case (i_req.cmd)
                        CMD_LOOKUP:      n_state = S_LK1;
                        CMD_UPDATE:      n_state = S_UPD;
                        CMD_HIST_SHIFT:  n_state = S_SPEC;
                        CMD_RECOVER: begin
                            if (w_ib == '0) begin
                                w_h_we    = 1'b1;
                                w_h_waddr = '0;
                                w_h_wdata = {i_req.history_snapshot[HIST_W-2:0],
                                             i_req.direction_bit} & w_hmask;
                            end
                        end
                        CMD_FLUSH: begin
                            if (w_ib == '0) begin
                                w_h_we    = 1'b1;
                                w_h_waddr = '0;
                                w_h_wdata = i_req.history_snapshot;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_LK1: begin
                // history and chooser are out; fetch the counter pair
                w_b_re   = 1'b1;
                n_p_hist = w_h_rdata;
                n_p_bank = w_sel;
                n_state  = S_LK2;
            end
            S_LK2: begin
                n_p_pred = r_p_bank ? w_b_rdata[3] : w_b_rdata[1];
                n_state  = S_DONE;
            end
            S_UPD: begin
                w_b_we    = 1'b1;
                w_b_waddr = r_li;
                w_b_wdata = r_bank ? {w_ctr_new, w_b_rdata[1:0]}
                                   : {w_b_rdata[3:2], w_ctr_new};
                // chooser keeps its value when the bank was right against it
                if (!(w_pred == r_dir && w_sel != r_dir)) begin
                    w_c_we    = 1'b1;
                    w_c_waddr = r_ci;
                    w_c_wdata = ctr_train(w_c_rdata, r_dir);
                end
                n_state = S_DONE;
            end
            S_SPEC: begin
                w_h_we    = 1'b1;
                w_h_waddr = r_hi;
                w_h_wdata = {w_h_rdata[HIST_W-2:0], r_dir} & w_hmask;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_pred  = r_p_pred;
                    n_out_hist  = r_p_hist;
                    n_out_bank  = r_p_bank;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pc       <= n_pc;
        r_hi       <= n_hi;
        r_ci       <= n_ci;
        r_li       <= n_li;
        r_bank     <= n_bank;
        r_dir      <= n_dir;
        r_p_pred   <= n_p_pred;
        r_p_hist   <= n_p_hist;
        r_p_bank   <= n_p_bank;
        r_out_pred <= n_out_pred;
        r_out_hist <= n_out_hist;
        r_out_bank <= n_out_bank;
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.predict_taken = r_out_pred;
    assign o_rsp.history_out   = r_out_hist;
    assign o_rsp.bank_out      = r_out_bank;

    bimode_ram #(.WIDTH(HIST_W), .DEPTH(HISTORY_ENTRIES)) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (w_h_we),
        .i_waddr (w_h_waddr),
        .i_wdata (w_h_wdata),
        .i_re    (w_h_re),
        .i_raddr (w_h_raddr),
        .o_rdata (w_h_rdata)
    );

    bimode_ram #(.WIDTH(2), .DEPTH(COUNTER_ENTRIES)) u_choose_ram (
        .i_clk   (i_clk),
        .i_we    (w_c_we),
        .i_waddr (w_c_waddr),
        .i_wdata (w_c_wdata),
        .i_re    (w_c_re),
        .i_raddr (w_c_raddr),
        .o_rdata (w_c_rdata)
    );

    // both direction banks share one index, kept side by side: taken in [3:2]
    bimode_ram #(.WIDTH(4), .DEPTH(COUNTER_ENTRIES)) u_bank_ram (
        .i_clk   (i_clk),
        .i_we    (w_b_we),
        .i_waddr (w_b_waddr),
        .i_wdata (w_b_wdata),
        .i_re    (w_b_re),
        .i_raddr (w_b_raddr),
        .o_rdata (w_b_rdata)
    );
endmodule
